>>> sv/wavc_pkg.sv
`default_nettype none
package wavc_pkg;

    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam int unsigned VOL_W     = 9;
    localparam int unsigned GAIN_W    = VOL_W + 1;
    localparam logic [VOL_W-1:0] VOLUME_RESET = 9'd153;
    localparam logic [VOL_W-1:0] VOLUME_UNITY = 9'd256;

    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLUME = 1'b0,
        REG_DOCKED = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_CHDR  = 4'd1,
        PH_FMT   = 4'd2,
        PH_SKIP  = 4'd3,
        PH_DATA  = 4'd4,
        PH_DRAIN = 4'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_SAMPLE  = 3'd0,
        ST_OK      = 3'd1,
        ST_BAD_HDR = 3'd2,
        ST_BAD_FMT = 3'd3,
        ST_NO_DATA = 3'd4,
        ST_TRUNC   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        STEP_FIRST  = 2'd0,
        STEP_SECOND = 2'd1,
        STEP_STATUS = 2'd2
    } t_step;

    // One command per accepted byte that yields anything: a sample, a status, or both.
    typedef struct packed {
        logic               has_smp;
        logic               is8;
        logic               mono;
        logic               chan;
        logic signed [15:0] value;
        logic               has_stat;
        t_status            stat;
    } t_cmd;

endpackage
`default_nettype wire

>>> sv/wav_pcm_stream_converter_core.sv
// WAV byte stream to signed 16-bit PCM sample stream.
// Input side is a queue write port: present a file byte on i_file_byte (and
// i_end_of_file on the final byte) with push; the byte is taken on any edge
// where push is high and full is low. Output side is a queue read port: while
// empty is low the oldest word sits on o_sample/o_channel/o_status/o_last and
// is taken on an edge where pop is high. Sample words carry status 0; every
// file ends with one status word with o_last set.
// Volume (index 0) and docked mode (index 1) are written over the cfg port,
// which is always ready; write them only while no file bytes are in flight.
// The parser takes one byte per cycle while full is low; the output register
// sends one word per cycle while pop keeps it free, so mono 8-bit data, which
// yields two words per byte, sustains one byte per two words.
// When pop is held low, results collect in a four-entry command queue and
// full rises once it fills. Reset clears the parser, queue and output stage
// and sets volume to 153 and docked mode off.
`default_nettype none
module wav_pcm_stream_converter_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [7:0]                     i_file_byte,
    input  wire logic                           i_end_of_file,
    output logic                                empty,
    input  wire logic                           pop,
    output logic signed [15:0]                  o_sample,
    output logic                                o_channel,
    output logic [2:0]                          o_status,
    output logic                                o_last,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [wavc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wavc_pkg::VOL_W-1:0]     i_cfg_data
);
    import wavc_pkg::*;

    logic [VOL_W-1:0]  r_volume;
    logic              r_docked;
    logic [VOL_W-1:0]  w_vol_sat;
    logic [GAIN_W-1:0] w_gain2;

    logic   w_accept, w_cmd_valid, w_q_full, w_q_empty, w_q_pop;
    t_cmd   w_cmd, w_q_head;
    t_phase w_phase;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOLUME_RESET;
            r_docked <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VOLUME: r_volume <= i_cfg_data;
                REG_DOCKED: r_docked <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_vol_sat = (r_volume > VOLUME_UNITY) ? VOLUME_UNITY : r_volume;
    assign w_gain2   = r_docked ? {1'b0, w_vol_sat} : {w_vol_sat, 1'b0};

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    wavc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_byte      (i_file_byte),
        .i_eof       (i_end_of_file),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .o_phase     (w_phase)
    );

    wavc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_data  (w_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_head),
        .o_empty (w_q_empty)
    );

    wavc_scaler u_scaler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_q_empty),
        .i_cmd       (w_q_head),
        .o_cmd_pop   (w_q_pop),
        .i_gain2     (w_gain2),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_sample    (o_sample),
        .o_channel   (o_channel),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    a_eof_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_end_of_file) |=> (w_phase == PH_RIFF))
        else $error("parser did not restart after end of file");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last == (o_status != ST_SAMPLE)))
        else $error("last flag and status code disagree");

    a_status_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_sample == 16'sd0 && !o_channel))
        else $error("status word carries sample data");

endmodule
`default_nettype wire

>>> sv/wavc_parser.sv
`default_nettype none
module wavc_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_eof,
    output logic                o_cmd_valid,
    output wavc_pkg::t_cmd      o_cmd,
    output wavc_pkg::t_phase    o_phase
);
    import wavc_pkg::*;

    localparam logic [3:0] IDX_RIFF_END = 4'd3;
    localparam logic [3:0] IDX_WAVE_END = 4'd11;
    localparam logic [3:0] IDX_ID_END   = 4'd3;
    localparam logic [3:0] IDX_SIZE_END = 4'd7;
    localparam logic [3:0] IDX_SIZE_BEG = 4'd4;
    localparam logic [3:0] IDX_FMT_LO   = 4'd0;
    localparam logic [3:0] IDX_FMT_HI   = 4'd1;
    localparam logic [3:0] IDX_CH_LO    = 4'd2;
    localparam logic [3:0] IDX_CH_HI    = 4'd3;
    localparam logic [3:0] IDX_BITS_LO  = 4'd14;
    localparam logic [3:0] IDX_BITS_HI  = 4'd15;
    localparam logic [31:0] FMT_BODY    = 32'd16;

    t_phase       r_phase, n_phase, w_mid;
    logic [3:0]   r_idx, n_idx;
    logic [31:0]  r_size, n_size;
    logic [31:0]  r_shift, n_shift;
    logic [15:0]  r_fmt_code, n_fmt_code;
    logic [15:0]  r_chan_cnt, n_chan_cnt;
    logic [15:0]  r_bits, n_bits;
    logic [31:0]  r_left, n_left;
    logic [7:0]   r_low, n_low;

    logic [31:0]  w_shl, w_shr, w_data_left, w_left_dec, w_fmt_rest, w_skip_dec;
    logic         w_fmt_bad, w_is8, w_smp_now, w_fin, w_eof_stat;
    t_status      w_fin_st, w_eof_st;
    t_cmd         w_cmd;

    assign w_shl       = {r_shift[23:0], i_byte};
    assign w_shr       = {i_byte, r_shift[31:8]};
    assign w_fmt_bad   = (r_fmt_code != 16'd1) || (r_chan_cnt == 16'd0) ||
                         (r_chan_cnt > 16'd2) || ((r_bits != 16'd8) && (r_bits != 16'd16));
    assign w_is8       = (r_bits == 16'd8);
    assign w_data_left = w_is8 ? w_shr : {1'b0, w_shr[31:1]};
    assign w_left_dec  = r_left - 32'd1;
    assign w_fmt_rest  = (r_size > FMT_BODY) ? (r_size - FMT_BODY) : 32'd0;
    assign w_skip_dec  = r_size - 32'd1;
    assign w_smp_now   = (r_phase == PH_DATA) && (w_is8 || r_idx[0]);

    // next phase and the status that the byte itself raises
    always_comb begin
        w_mid    = r_phase;
        w_fin    = 1'b0;
        w_fin_st = ST_OK;
        case (r_phase)
            PH_RIFF: begin
                if (r_idx == IDX_RIFF_END && w_shl != TAG_RIFF) begin
                    w_fin    = 1'b1;
                    w_fin_st = ST_BAD_HDR;
                end else if (r_idx == IDX_WAVE_END) begin
                    if (w_shl != TAG_WAVE) begin
                        w_fin    = 1'b1;
                        w_fin_st = ST_BAD_HDR;
                    end else begin
                        w_mid = PH_CHDR;
                    end
                end
            end
            PH_CHDR: begin
                if (r_idx == IDX_SIZE_END) begin
                    if (r_size == TAG_FMT) begin
                        w_mid = PH_FMT;
                    end else if (r_size == TAG_DATA) begin
                        if (w_fmt_bad) begin
                            w_fin    = 1'b1;
                            w_fin_st = ST_BAD_FMT;
                        end else if (w_shr == 32'd0) begin
                            w_fin    = 1'b1;
                            w_fin_st = ST_NO_DATA;
                        end else if (w_data_left == 32'd0) begin
                            w_fin    = 1'b1;
                            w_fin_st = ST_OK;
                        end else begin
                            w_mid = PH_DATA;
                        end
                    end else begin
                        w_mid = (w_shr != 32'd0) ? PH_SKIP : PH_CHDR;
                    end
                end
            end
            PH_FMT: begin
                if (r_idx == IDX_BITS_HI) begin
                    w_mid = (w_fmt_rest != 32'd0) ? PH_SKIP : PH_CHDR;
                end
            end
            PH_SKIP: begin
                if (w_skip_dec == 32'd0) begin
                    w_mid = PH_CHDR;
                end
            end
            PH_DATA: begin
                if (w_smp_now && w_left_dec == 32'd0) begin
                    w_fin    = 1'b1;
                    w_fin_st = ST_OK;
                end
            end
            default: begin
            end
        endcase
        if (w_fin) begin
            w_mid = PH_DRAIN;
        end
        n_phase = i_eof ? PH_RIFF : w_mid;
    end

    // status raised by the end of the file, judged on the phase after this byte
    always_comb begin
        w_eof_stat = i_eof;
        w_eof_st   = ST_OK;
        case (w_mid)
            PH_RIFF:                   w_eof_st = ST_BAD_HDR;
            PH_CHDR, PH_FMT, PH_SKIP:  w_eof_st = ST_NO_DATA;
            PH_DATA:                   w_eof_st = ST_TRUNC;
            default:                   w_eof_stat = 1'b0;
        endcase
    end

    // field capture and command build
    always_comb begin
        n_idx      = r_idx;
        n_size     = r_size;
        n_shift    = r_shift;
        n_fmt_code = r_fmt_code;
        n_chan_cnt = r_chan_cnt;
        n_bits     = r_bits;
        n_left     = r_left;
        n_low      = r_low;
        case (r_phase)
            PH_RIFF: begin
                n_shift = w_shl;
                n_idx   = r_idx + 4'd1;
                if (w_mid == PH_CHDR) begin
                    n_shift = '0;
                    n_idx   = '0;
                end
            end
            PH_CHDR: begin
                n_idx   = r_idx + 4'd1;
                n_shift = (r_idx < IDX_SIZE_BEG) ? w_shl : w_shr;
                if (r_idx == IDX_ID_END) begin
                    n_size  = w_shl;
                    n_shift = '0;
                end else if (r_idx == IDX_SIZE_END) begin
                    n_size  = w_shr;
                    n_shift = '0;
                    n_idx   = '0;
                    if (r_size == TAG_DATA && !w_fmt_bad && w_shr != 32'd0) begin
                        n_left = w_data_left;
                    end
                end
            end
            PH_FMT: begin
                n_idx = r_idx + 4'd1;
                case (r_idx)
                    IDX_FMT_LO:  n_fmt_code = {8'd0, i_byte};
                    IDX_FMT_HI:  n_fmt_code = {i_byte, r_fmt_code[7:0]};
                    IDX_CH_LO:   n_chan_cnt = {8'd0, i_byte};
                    IDX_CH_HI:   n_chan_cnt = {i_byte, r_chan_cnt[7:0]};
                    IDX_BITS_LO: n_bits     = {8'd0, i_byte};
                    IDX_BITS_HI: n_bits     = {i_byte, r_bits[7:0]};
                    default: begin
                    end
                endcase
                if (r_idx == IDX_BITS_HI) begin
                    n_size = w_fmt_rest;
                    n_idx  = '0;
                end
            end
            PH_SKIP: begin
                n_size = w_skip_dec;
                n_idx  = '0;
            end
            PH_DATA: begin
                n_idx = r_idx + 4'd1;
                if (!w_is8 && !r_idx[0]) begin
                    n_low = i_byte;
                end
                if (w_smp_now) begin
                    n_left = w_left_dec;
                end
            end
            default: begin
            end
        endcase

        w_cmd.has_smp  = w_smp_now;
        w_cmd.is8      = w_is8;
        w_cmd.mono     = (r_chan_cnt == 16'd1);
        w_cmd.chan     = w_is8 ? r_idx[0] : r_idx[1];
        w_cmd.value    = w_is8 ? {{8{~i_byte[7]}}, ~i_byte[7], i_byte[6:0]}
                               : {i_byte, r_low};
        w_cmd.has_stat = w_fin || w_eof_stat;
        w_cmd.stat     = w_fin ? w_fin_st : w_eof_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_eof)) begin
            r_phase    <= PH_RIFF;
            r_idx      <= '0;
            r_size     <= '0;
            r_shift    <= '0;
            r_fmt_code <= '0;
            r_chan_cnt <= '0;
            r_bits     <= '0;
            r_left     <= '0;
            r_low      <= '0;
        end else if (i_valid) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_size     <= n_size;
            r_shift    <= n_shift;
            r_fmt_code <= n_fmt_code;
            r_chan_cnt <= n_chan_cnt;
            r_bits     <= n_bits;
            r_left     <= n_left;
            r_low      <= n_low;
        end
    end

    assign o_cmd_valid = i_valid && (w_cmd.has_smp || w_cmd.has_stat);
    assign o_cmd       = w_cmd;
    assign o_phase     = r_phase;

endmodule
`default_nettype wire

>>> sv/wavc_cmd_queue.sv
`default_nettype none
module wavc_cmd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wavc_pkg::t_cmd      i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output wavc_pkg::t_cmd      o_data,
    output logic                o_empty
);
    import wavc_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CMDQ_PTR_W:0]   r_count;
    logic                  w_do_push, w_do_pop;

    assign o_full    = (r_count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/wavc_scaler.sv
`default_nettype none
module wavc_scaler (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_empty,
    input  wavc_pkg::t_cmd                   i_cmd,
    output logic                             o_cmd_pop,
    input  wire logic [wavc_pkg::GAIN_W-1:0] i_gain2,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic signed [15:0]               o_sample,
    output logic                             o_channel,
    output logic [2:0]                       o_status,
    output logic                             o_last
);
    import wavc_pkg::*;

    localparam int unsigned PROD_W = 27;

    logic                     r_s1_valid;
    t_cmd                     r_s1;
    logic signed [PROD_W-1:0] r_prod;
    t_step                    r_step, n_step;

    logic                     r_out_valid;
    logic signed [15:0]       r_out_sample;
    logic                     r_out_chan;
    t_status                  r_out_stat;
    logic                     r_out_last;

    logic [GAIN_W-1:0]        w_gain_op;
    logic signed [PROD_W-1:0] w_val_ext, w_gain_ext, w_prod, w_round;
    logic signed [15:0]       w_scaled, w_word_sample;
    logic                     w_word_chan, w_word_last, w_done, w_out_free, w_emit, w_load;
    t_status                  w_word_stat;
    t_step                    w_start;

    // 8-bit samples use the halved gain; 16-bit ones the full gain and a /512 afterwards
    assign w_gain_op  = i_cmd.is8 ? {1'b0, i_gain2[GAIN_W-1:1]} : i_gain2;
    assign w_val_ext  = {{(PROD_W-16){i_cmd.value[15]}}, i_cmd.value};
    assign w_gain_ext = {{(PROD_W-GAIN_W){1'b0}}, w_gain_op};
    assign w_prod     = w_val_ext * w_gain_ext;

    // truncate toward zero: bias negatives by 511 before the arithmetic shift
    assign w_round  = r_prod + (r_prod[PROD_W-1] ? 27'sd511 : 27'sd0);
    assign w_scaled = r_s1.is8 ? r_prod[15:0] : w_round[24:9];

    assign w_out_free = !r_out_valid || i_pop;
    assign w_emit     = r_s1_valid && w_out_free;
    assign w_start    = i_cmd.has_smp ? STEP_FIRST : STEP_STATUS;
    assign w_load     = !i_cmd_empty && (!r_s1_valid || (w_emit && w_done));
    assign o_cmd_pop  = w_load;

    // next step of the word sequence for the held command
    always_comb begin
        n_step = r_step;
        w_done = 1'b0;
        case (r_step)
            STEP_FIRST: begin
                if (r_s1.mono) begin
                    n_step = STEP_SECOND;
                end else if (r_s1.has_stat) begin
                    n_step = STEP_STATUS;
                end else begin
                    w_done = 1'b1;
                end
            end
            STEP_SECOND: begin
                if (r_s1.has_stat) begin
                    n_step = STEP_STATUS;
                end else begin
                    w_done = 1'b1;
                end
            end
            STEP_STATUS: w_done = 1'b1;
            default:     w_done = 1'b1;
        endcase
    end

    // word for the current step
    always_comb begin
        w_word_sample = w_scaled;
        w_word_chan   = 1'b0;
        w_word_stat   = ST_SAMPLE;
        w_word_last   = 1'b0;
        case (r_step)
            STEP_FIRST:  w_word_chan = r_s1.mono ? 1'b0 : r_s1.chan;
            STEP_SECOND: w_word_chan = 1'b1;
            STEP_STATUS: begin
                w_word_sample = '0;
                w_word_stat   = r_s1.stat;
                w_word_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_step     <= STEP_FIRST;
        end else if (w_load) begin
            r_s1_valid <= 1'b1;
            r_step     <= w_start;
        end else if (w_emit) begin
            if (w_done) begin
                r_s1_valid <= 1'b0;
            end else begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1   <= i_cmd;
            r_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_sample <= w_word_sample;
            r_out_chan   <= w_word_chan;
            r_out_stat   <= w_word_stat;
            r_out_last   <= w_word_last;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_sample  = r_out_sample;
    assign o_channel = r_out_chan;
    assign o_status  = r_out_stat;
    assign o_last    = r_out_last;

endmodule
`default_nettype wire
